// File: design/sit_pkg.sv
// Package for the symbol and integer tokenizer.
// Holds the scan modes, the result record, the character codes and the
// character-class functions. It depends on nothing.
package sit_pkg;

    // Limits of the token lengths.
    localparam int MAX_SYMBOL_LENGTH  = 127;
    localparam int MAX_INTEGER_DIGITS = 18;
    localparam int SYM_LEN_W          = $clog2(MAX_SYMBOL_LENGTH + 1);
    localparam int DIGIT_CNT_W        = $clog2(MAX_INTEGER_DIGITS + 1);

    // Field widths of a result beat.
    localparam int VALUE_W = 60;
    localparam int POS_W   = 32;

    // Result queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds.
    localparam logic [1:0] KIND_SYMBOL  = 2'd0;
    localparam logic [1:0] KIND_INTEGER = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_LONE_SEMI  = 2'd0;
    localparam logic [1:0] ERR_SYM_LONG   = 2'd1;
    localparam logic [1:0] ERR_INT_LONG   = 2'd2;
    localparam logic [1:0] ERR_BAD_START  = 2'd3;

    // Character codes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SEMI,
        MODE_COMMENT,
        MODE_SYMBOL,
        MODE_INTEGER,
        MODE_HALTED
    } t_mode;

    // One result beat.
    typedef struct packed {
        logic [1:0]         token_kind;
        logic [7:0]         symbol_char;
        logic               symbol_last;
        logic [VALUE_W-1:0] integer_value;
        logic [1:0]         error_kind;
        logic [POS_W-1:0]   error_line;
        logic [POS_W-1:0]   error_column;
        logic               run_last;
    } t_result;

    // Up to two results that one source byte pushes into the queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_symbol_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CHAR_UNDER) || (c == CHAR_COLON);
    endfunction

endpackage

// File: design/sit_front.sv
// Scanner front end: takes one source byte a beat, keeps the scan state
// and the source position, and pushes zero, one or two results.
// Depends on sit_pkg.
module sit_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_room,
    output sit_pkg::t_push  o_push
);

    sit_pkg::t_mode                         r_mode, n_mode;
    logic [7:0]                             r_pending, n_pending;
    logic [sit_pkg::SYM_LEN_W-1:0]          r_sym_len, n_sym_len;
    logic [sit_pkg::VALUE_W-1:0]            r_acc, n_acc;
    logic [sit_pkg::DIGIT_CNT_W-1:0]        r_digits, n_digits;
    logic [sit_pkg::POS_W-1:0]              r_line, n_line;
    logic [sit_pkg::POS_W-1:0]              r_col, n_col;

    logic                                   take;
    sit_pkg::t_mode                         bt_mode;
    logic                                   bt_has;
    sit_pkg::t_result                       bt_res;
    logic                                   bt_sym;
    logic                                   bt_int;
    logic                                   use_bt;
    logic [1:0]                             nres;
    sit_pkg::t_result                       res_a;
    logic [sit_pkg::VALUE_W-1:0]            digit_val;
    logic [sit_pkg::VALUE_W-1:0]            acc_next;

    // A byte is taken whenever the queue has room for two results.
    assign o_ready = i_room;
    assign take    = i_valid && i_room;

    // Digit value and the next accumulator (times ten as two shifts and an add).
    assign digit_val = sit_pkg::VALUE_W'(i_byte[3:0]);
    assign acc_next  = (r_acc << 3) + (r_acc << 1) + digit_val;

    // Handling of a byte that falls between tokens.
    always_comb begin
        bt_mode = sit_pkg::MODE_IDLE;
        bt_has  = 1'b0;
        bt_res  = '0;
        bt_sym  = 1'b0;
        bt_int  = 1'b0;
        priority if (i_byte == sit_pkg::CHAR_NUL) begin
            bt_has            = 1'b1;
            bt_res.token_kind = sit_pkg::KIND_END;
            bt_mode           = sit_pkg::MODE_HALTED;
        end else if (sit_pkg::is_space(i_byte)) begin
            bt_mode = sit_pkg::MODE_IDLE;
        end else if (i_byte == sit_pkg::CHAR_SEMI) begin
            bt_mode = sit_pkg::MODE_SEMI;
        end else if (sit_pkg::is_alpha(i_byte)) begin
            bt_mode = sit_pkg::MODE_SYMBOL;
            bt_sym  = 1'b1;
        end else if (sit_pkg::is_digit(i_byte)) begin
            bt_mode = sit_pkg::MODE_INTEGER;
            bt_int  = 1'b1;
        end else begin
            bt_has              = 1'b1;
            bt_res.token_kind   = sit_pkg::KIND_ERROR;
            bt_res.error_kind   = sit_pkg::ERR_BAD_START;
            bt_res.error_line   = r_line;
            bt_res.error_column = r_col;
            bt_mode             = sit_pkg::MODE_HALTED;
        end
    end

    // Main scan step: state update and the results of this byte.
    always_comb begin
        n_mode    = r_mode;
        n_pending = r_pending;
        n_sym_len = r_sym_len;
        n_acc     = r_acc;
        n_digits  = r_digits;
        n_line    = r_line;
        n_col     = r_col;
        use_bt    = 1'b0;
        nres      = 2'd0;
        res_a     = '0;

        if (r_mode != sit_pkg::MODE_HALTED) begin
            if (i_byte == sit_pkg::CHAR_NL) begin
                n_line = r_line + 1'b1;
                n_col  = sit_pkg::POS_W'(1);
            end else begin
                n_col  = r_col + 1'b1;
            end
        end

        unique case (r_mode)
            sit_pkg::MODE_SEMI: begin
                if (i_byte == sit_pkg::CHAR_SEMI) begin
                    n_mode = sit_pkg::MODE_COMMENT;
                end else begin
                    nres               = 2'd1;
                    res_a.token_kind   = sit_pkg::KIND_ERROR;
                    res_a.error_kind   = sit_pkg::ERR_LONE_SEMI;
                    res_a.error_line   = r_line;
                    res_a.error_column = r_col;
                    n_mode             = sit_pkg::MODE_HALTED;
                end
            end
            sit_pkg::MODE_COMMENT: begin
                if (i_byte == sit_pkg::CHAR_NL) begin
                    n_mode = sit_pkg::MODE_IDLE;
                end else if (i_byte == sit_pkg::CHAR_NUL) begin
                    nres             = 2'd1;
                    res_a.token_kind = sit_pkg::KIND_END;
                    n_mode           = sit_pkg::MODE_HALTED;
                end
            end
            sit_pkg::MODE_SYMBOL: begin
                if (sit_pkg::is_symbol_char(i_byte)) begin
                    nres = 2'd1;
                    if (r_sym_len >= sit_pkg::SYM_LEN_W'(sit_pkg::MAX_SYMBOL_LENGTH)) begin
                        res_a.token_kind   = sit_pkg::KIND_ERROR;
                        res_a.error_kind   = sit_pkg::ERR_SYM_LONG;
                        res_a.error_line   = r_line;
                        res_a.error_column = r_col;
                        n_mode             = sit_pkg::MODE_HALTED;
                    end else begin
                        res_a.token_kind  = sit_pkg::KIND_SYMBOL;
                        res_a.symbol_char = r_pending;
                        n_pending         = i_byte;
                        n_sym_len         = r_sym_len + 1'b1;
                    end
                end else begin
                    // The symbol ends: flag its last character, then rescan the byte.
                    res_a.token_kind  = sit_pkg::KIND_SYMBOL;
                    res_a.symbol_char = r_pending;
                    res_a.symbol_last = 1'b1;
                    n_sym_len         = '0;
                    n_pending         = '0;
                    use_bt            = 1'b1;
                    nres              = bt_has ? 2'd2 : 2'd1;
                end
            end
            sit_pkg::MODE_INTEGER: begin
                if (sit_pkg::is_digit(i_byte)) begin
                    if (r_digits >= sit_pkg::DIGIT_CNT_W'(sit_pkg::MAX_INTEGER_DIGITS)) begin
                        nres               = 2'd1;
                        res_a.token_kind   = sit_pkg::KIND_ERROR;
                        res_a.error_kind   = sit_pkg::ERR_INT_LONG;
                        res_a.error_line   = r_line;
                        res_a.error_column = r_col;
                        n_mode             = sit_pkg::MODE_HALTED;
                    end else begin
                        n_acc    = acc_next;
                        n_digits = r_digits + 1'b1;
                    end
                end else begin
                    // The integer ends: report it, then rescan the byte.
                    res_a.token_kind    = sit_pkg::KIND_INTEGER;
                    res_a.integer_value = r_acc;
                    n_acc               = '0;
                    n_digits            = '0;
                    use_bt              = 1'b1;
                    nres                = bt_has ? 2'd2 : 2'd1;
                end
            end
            sit_pkg::MODE_IDLE: begin
                use_bt = 1'b1;
                res_a  = bt_res;
                nres   = bt_has ? 2'd1 : 2'd0;
            end
            sit_pkg::MODE_HALTED: begin
                nres = 2'd0;
            end
            default: begin
                nres = 2'd0;
            end
        endcase

        // Side effects of a byte handled between tokens.
        if (use_bt) begin
            n_mode = bt_mode;
            if (bt_sym) begin
                n_pending = i_byte;
                n_sym_len = sit_pkg::SYM_LEN_W'(1);
            end
            if (bt_int) begin
                n_acc    = digit_val;
                n_digits = sit_pkg::DIGIT_CNT_W'(1);
            end
        end
    end

    // Results handed to the queue; the last one of the byte is flagged.
    always_comb begin
        o_push                 = '0;
        o_push.count           = take ? nres : 2'd0;
        o_push.first           = res_a;
        o_push.first.run_last  = (nres == 2'd1);
        o_push.second          = bt_res;
        o_push.second.run_last = 1'b1;
    end

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= sit_pkg::MODE_IDLE;
            r_pending <= '0;
            r_sym_len <= '0;
            r_acc     <= '0;
            r_digits  <= '0;
            r_line    <= sit_pkg::POS_W'(1);
            r_col     <= sit_pkg::POS_W'(1);
        end else if (take) begin
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_sym_len <= n_sym_len;
            r_acc     <= n_acc;
            r_digits  <= n_digits;
            r_line    <= n_line;
            r_col     <= n_col;
        end
    end

endmodule

// File: design/sit_queue.sv
// Result queue between the scanner and the output stage.
// Takes up to two results a cycle and gives one whenever the output stage pops. Depends on sit_pkg.
module sit_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sit_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_head_valid,
    output sit_pkg::t_result  o_head,
    input  logic              i_pop
);

    sit_pkg::t_result                  r_mem [sit_pkg::QUEUE_DEPTH];
    logic [sit_pkg::QPTR_W-1:0]        r_wp, n_wp;
    logic [sit_pkg::QPTR_W-1:0]        r_rp, n_rp;
    logic [sit_pkg::QCNT_W-1:0]        r_cnt, n_cnt;
    logic [sit_pkg::QPTR_W-1:0]        wp_next;
    logic                              pop;

    // Room for the two results that one byte can cause.
    assign o_room       = (r_cnt <= sit_pkg::QCNT_W'(sit_pkg::QUEUE_DEPTH - 2));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign pop          = i_pop && o_head_valid;
    assign wp_next      = r_wp + 1'b1;

    // Pointer and fill count update.
    always_comb begin
        n_wp  = r_wp + sit_pkg::QPTR_W'(i_push.count);
        n_rp  = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + sit_pkg::QCNT_W'(i_push.count) - sit_pkg::QCNT_W'(pop);
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp_next] <= i_push.second;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: design/sit_back.sv
// Output stage: moves results from the queue into the output register
// and holds each beat until the consumer takes it. Depends on sit_pkg.
module sit_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  sit_pkg::t_result  i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output sit_pkg::t_result  o_res
);

    logic              r_valid;
    sit_pkg::t_result  r_res;
    logic              load;

    // The register loads when it is empty or its beat is being taken.
    assign load    = !r_valid || i_ready;
    assign o_pop   = load && i_head_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_head_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

endmodule

// File: design/symbol_integer_tokenizer.sv
// Top level of the symbol and integer tokenizer.
// Connects the scanner, the result queue and the output stage; uses sit_pkg.
//
// The tokenizer takes one source byte a beat, at up to one byte every cycle
// while the queue has room. A byte gives zero, one or two result beats;
// the output stage delivers one result beat a cycle when the consumer is
// ready, so the input rate is one byte a cycle whenever bytes give at most
// one result on average and the consumer is ready. A result is written
// into a four-entry queue as its byte is taken and then moves into the
// output register. The input is ready while the queue has room for two
// results. After an end of source or an error, bytes are still taken but
// give nothing until reset.
module symbol_integer_tokenizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_source_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_token_kind,
    output logic [7:0]                    o_symbol_char,
    output logic                          o_symbol_last,
    output logic [sit_pkg::VALUE_W-1:0]   o_integer_value,
    output logic [1:0]                    o_error_kind,
    output logic [sit_pkg::POS_W-1:0]     o_error_line,
    output logic [sit_pkg::POS_W-1:0]     o_error_column,
    output logic                          o_run_last
);

    sit_pkg::t_push    push;
    logic              room;
    logic              head_valid;
    sit_pkg::t_result  head;
    logic              pop;
    sit_pkg::t_result  res;

    // Scanner.
    sit_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_source_byte),
        .i_room  (room),
        .o_push  (push)
    );

    // Result queue.
    sit_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_room       (room),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Output stage.
    sit_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_res        (res)
    );

    // Result fields onto their ports.
    assign o_token_kind    = res.token_kind;
    assign o_symbol_char   = res.symbol_char;
    assign o_symbol_last   = res.symbol_last;
    assign o_integer_value = res.integer_value;
    assign o_error_kind    = res.error_kind;
    assign o_error_line    = res.error_line;
    assign o_error_column  = res.error_column;
    assign o_run_last      = res.run_last;

endmodule

// File: design/sit_checker.sv
// Port checker for the symbol and integer tokenizer, bound to the top level.
// Depends on sit_pkg.
module sit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    o_token_kind,
    input  logic [7:0]                    o_symbol_char,
    input  logic                          o_symbol_last,
    input  logic [sit_pkg::VALUE_W-1:0]   o_integer_value,
    input  logic [1:0]                    o_error_kind,
    input  logic [sit_pkg::POS_W-1:0]     o_error_line,
    input  logic [sit_pkg::POS_W-1:0]     o_error_column,
    input  logic                          o_run_last
);

    // A stalled result beat stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_kind)
            && $stable(o_symbol_char) && $stable(o_integer_value)
            && $stable(o_error_line) && $stable(o_error_column))
        else $error("result beat changed while stalled");

    // End of source and errors are always the last result of their byte.
    a_halt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == sit_pkg::KIND_END
            || o_token_kind == sit_pkg::KIND_ERROR) |-> o_run_last)
        else $error("end or error beat not marked last of its byte");

    // Nothing follows an end of source or an error.
    a_halt_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_token_kind == sit_pkg::KIND_END
            || o_token_kind == sit_pkg::KIND_ERROR) |=> !o_out_valid)
        else $error("result after the block halted");

    // Only symbol beats carry symbol fields; only error beats carry a position.
    a_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind != sit_pkg::KIND_ERROR |-> o_error_line == '0
            && o_error_column == '0 && o_error_kind == '0
            && (o_token_kind == sit_pkg::KIND_SYMBOL
                || (!o_symbol_last && o_symbol_char == '0)))
        else $error("field set on a beat of another kind");

endmodule

bind symbol_integer_tokenizer sit_checker u_sit_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_token_kind    (o_token_kind),
    .o_symbol_char   (o_symbol_char),
    .o_symbol_last   (o_symbol_last),
    .o_integer_value (o_integer_value),
    .o_error_kind    (o_error_kind),
    .o_error_line    (o_error_line),
    .o_error_column  (o_error_column),
    .o_run_last      (o_run_last)
);

// File: bench/token_stream_checker.sv
// Checker for the symbol and integer tokenizer: watches both beat channels,
// predicts the result beats of every accepted source byte and compares them.
// Depends on sit_pkg for the result record, token kinds, error codes and modes.
module token_stream_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [7:0]                  i_source_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [1:0]                  i_token_kind,
    input  logic [7:0]                  i_symbol_char,
    input  logic                        i_symbol_last,
    input  logic [sit_pkg::VALUE_W-1:0] i_integer_value,
    input  logic [1:0]                  i_error_kind,
    input  logic [sit_pkg::POS_W-1:0]   i_error_line,
    input  logic [sit_pkg::POS_W-1:0]   i_error_column,
    input  logic                        i_run_last,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Scanner state as the tokenizer should hold it.
    sit_pkg::t_mode              scan_state;
    logic [7:0]                  held_char;
    int                          symbol_taken;
    logic [sit_pkg::VALUE_W-1:0] value_acc;
    int                          digits_taken;
    logic [sit_pkg::POS_W-1:0]   line_no;
    logic [sit_pkg::POS_W-1:0]   column_no;

    // Result beats of the current byte, and all beats still owed by the block.
    sit_pkg::t_result byte_beats[$];
    sit_pkg::t_result expected_beats[$];

    int fail_total    = 0;
    int pending_total = 0;
    int checked_total = 0;

    assign o_fail_count    = fail_total;
    assign o_pending       = pending_total;
    assign o_beats_checked = checked_total;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic continues_symbol(input logic [7:0] c);
        return is_letter(c) || is_numeral(c) || c == sit_pkg::CHAR_UNDER
            || c == sit_pkg::CHAR_COLON;
    endfunction

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0d ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_total++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic add_beat(input logic [1:0] kind, input logic [7:0] ch, input logic last,
                            input logic [sit_pkg::VALUE_W-1:0] value,
                            input logic [1:0] code,
                            input logic [sit_pkg::POS_W-1:0] eline,
                            input logic [sit_pkg::POS_W-1:0] ecol);
        sit_pkg::t_result beat;
        beat.token_kind    = kind;
        beat.symbol_char   = ch;
        beat.symbol_last   = last;
        beat.integer_value = value;
        beat.error_kind    = code;
        beat.error_line    = eline;
        beat.error_column  = ecol;
        beat.run_last      = 1'b0;
        byte_beats.push_back(beat);
    endtask

    // Any error gives one beat and halts the scanner until reset.
    task automatic raise_error(input logic [1:0] code, input logic [sit_pkg::POS_W-1:0] ln,
                               input logic [sit_pkg::POS_W-1:0] col);
        add_beat(sit_pkg::KIND_ERROR, 8'd0, 1'b0, '0, code, ln, col);
        scan_state = sit_pkg::MODE_HALTED;
    endtask

    // A byte seen between tokens: skip, start a token, end the source or fail.
    task automatic start_between(input logic [7:0] c, input logic [sit_pkg::POS_W-1:0] ln,
                                 input logic [sit_pkg::POS_W-1:0] col);
        if (c == sit_pkg::CHAR_NUL) begin
            add_beat(sit_pkg::KIND_END, 8'd0, 1'b0, '0, 2'd0, '0, '0);
            scan_state = sit_pkg::MODE_HALTED;
        end else if (is_blank(c)) begin
            scan_state = sit_pkg::MODE_IDLE;
        end else if (c == sit_pkg::CHAR_SEMI) begin
            scan_state = sit_pkg::MODE_SEMI;
        end else if (is_letter(c)) begin
            scan_state   = sit_pkg::MODE_SYMBOL;
            held_char    = c;
            symbol_taken = 1;
        end else if (is_numeral(c)) begin
            scan_state   = sit_pkg::MODE_INTEGER;
            value_acc    = {{(sit_pkg::VALUE_W-8){1'b0}}, c - 8'd48};
            digits_taken = 1;
        end else begin
            raise_error(sit_pkg::ERR_BAD_START, ln, col);
        end
    endtask

    // Work out the beats that one accepted source byte causes.
    task automatic scan_byte(input logic [7:0] c);
        logic [sit_pkg::POS_W-1:0] ln;
        logic [sit_pkg::POS_W-1:0] col;
        sit_pkg::t_result          tail;
        ln  = line_no;
        col = column_no;
        byte_beats.delete();
        if (scan_state == sit_pkg::MODE_HALTED)
            return;

        // The position always names the byte being scanned.
        if (c == sit_pkg::CHAR_NL) begin
            line_no   = line_no + 1;
            column_no = 1;
        end else begin
            column_no = column_no + 1;
        end

        case (scan_state)
            sit_pkg::MODE_SEMI: begin
                if (c == sit_pkg::CHAR_SEMI)
                    scan_state = sit_pkg::MODE_COMMENT;
                else
                    raise_error(sit_pkg::ERR_LONE_SEMI, ln, col);
            end
            sit_pkg::MODE_COMMENT: begin
                if (c == sit_pkg::CHAR_NL) begin
                    scan_state = sit_pkg::MODE_IDLE;
                end else if (c == sit_pkg::CHAR_NUL) begin
                    add_beat(sit_pkg::KIND_END, 8'd0, 1'b0, '0, 2'd0, '0, '0);
                    scan_state = sit_pkg::MODE_HALTED;
                end
            end
            sit_pkg::MODE_SYMBOL: begin
                // Characters go out one byte late so the last one can be flagged.
                if (continues_symbol(c)) begin
                    if (symbol_taken >= sit_pkg::MAX_SYMBOL_LENGTH) begin
                        raise_error(sit_pkg::ERR_SYM_LONG, ln, col);
                    end else begin
                        add_beat(sit_pkg::KIND_SYMBOL, held_char, 1'b0, '0, 2'd0, '0, '0);
                        held_char    = c;
                        symbol_taken = symbol_taken + 1;
                    end
                end else begin
                    add_beat(sit_pkg::KIND_SYMBOL, held_char, 1'b1, '0, 2'd0, '0, '0);
                    symbol_taken = 0;
                    held_char    = 8'd0;
                    start_between(c, ln, col);
                end
            end
            sit_pkg::MODE_INTEGER: begin
                if (is_numeral(c)) begin
                    if (digits_taken >= sit_pkg::MAX_INTEGER_DIGITS) begin
                        raise_error(sit_pkg::ERR_INT_LONG, ln, col);
                    end else begin
                        value_acc    = value_acc * 10
                                     + {{(sit_pkg::VALUE_W-8){1'b0}}, c - 8'd48};
                        digits_taken = digits_taken + 1;
                    end
                end else begin
                    add_beat(sit_pkg::KIND_INTEGER, 8'd0, 1'b0, value_acc, 2'd0, '0, '0);
                    value_acc    = '0;
                    digits_taken = 0;
                    start_between(c, ln, col);
                end
            end
            default: start_between(c, ln, col);
        endcase

        // The final beat of a byte carries the run mark.
        if (byte_beats.size() > 0) begin
            tail          = byte_beats.pop_back();
            tail.run_last = 1'b1;
            byte_beats.push_back(tail);
        end
        foreach (byte_beats[k])
            expected_beats.push_back(byte_beats[k]);
    endtask

    // Compare output beats first; a byte's beats cannot leave in its own cycle.
    always @(posedge i_clk) begin
        sit_pkg::t_result want;
        if (!i_rst_n) begin
            scan_state   = sit_pkg::MODE_IDLE;
            held_char    = 8'd0;
            symbol_taken = 0;
            value_acc    = '0;
            digits_taken = 0;
            line_no      = 1;
            column_no    = 1;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing expected, kind", i_token_kind, 0);
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("token_kind", i_token_kind, want.token_kind);
                    compare_field("symbol_char", i_symbol_char, want.symbol_char);
                    compare_field("symbol_last", i_symbol_last, want.symbol_last);
                    compare_field("integer_value", i_integer_value, want.integer_value);
                    compare_field("error_kind", i_error_kind, want.error_kind);
                    compare_field("error_line", i_error_line, want.error_line);
                    compare_field("error_column", i_error_column, want.error_column);
                    compare_field("run_last", i_run_last, want.run_last);
                    checked_total++;
                end
            end
            if (i_in_valid && i_in_ready)
                scan_byte(i_source_byte);
        end
        pending_total = expected_beats.size();
    end

endmodule

// File: bench/symbol_integer_tokenizer_tb.sv
// Top of the tokenizer testbench: builds a source text, feeds it byte by byte
// under several pacing phases and gives the verdict. Depends on sit_pkg, the
// tokenizer RTL and token_stream_checker, which does all prediction and beat checking.
module symbol_integer_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLOCK_PERIOD = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 500;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        FLOW_STEADY,
        FLOW_SENDER_GAPS,
        FLOW_RECEIVER_STALLS,
        FLOW_BOTH
    } t_flow;

    // How the source text ends; only one ending fits in a run, as it halts the block.
    typedef enum int {
        END_IDLE,
        END_AFTER_TOKEN,
        END_IN_COMMENT,
        STOP_LONE_SEMI,
        STOP_SYMBOL_LONG,
        STOP_INTEGER_LONG,
        STOP_BAD_START
    } t_stop_case;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic [7:0]                  source_byte = 8'd0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic [1:0]                  token_kind;
    logic [7:0]                  symbol_char;
    logic                        symbol_last;
    logic [sit_pkg::VALUE_W-1:0] integer_value;
    logic [1:0]                  error_kind;
    logic [sit_pkg::POS_W-1:0]   error_line;
    logic [sit_pkg::POS_W-1:0]   error_column;
    logic                        run_last;

    int         fail_count;
    int         pending;
    int         beats_checked;
    int         cycle_count = 0;
    int         bytes_sent  = 0;
    t_flow      flow        = FLOW_STEADY;
    logic       hold_off    = 1'b0;
    t_stop_case stop_case;
    logic [7:0] source_text[$];

    always #(CLOCK_PERIOD / 2) clk = ~clk;

    symbol_integer_tokenizer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_source_byte   (source_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_token_kind    (token_kind),
        .o_symbol_char   (symbol_char),
        .o_symbol_last   (symbol_last),
        .o_integer_value (integer_value),
        .o_error_kind    (error_kind),
        .o_error_line    (error_line),
        .o_error_column  (error_column),
        .o_run_last      (run_last)
    );

    token_stream_checker stream_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_source_byte   (source_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_token_kind    (token_kind),
        .i_symbol_char   (symbol_char),
        .i_symbol_last   (symbol_last),
        .i_integer_value (integer_value),
        .i_error_kind    (error_kind),
        .i_error_line    (error_line),
        .i_error_column  (error_column),
        .i_run_last      (run_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // Index 0..25 gives upper case, 26..51 lower case.
    function automatic logic [7:0] letter_at(input int idx);
        return (idx < 26) ? 8'(65 + idx) : 8'(97 + idx - 26);
    endfunction

    function automatic logic [7:0] random_comment_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == sit_pkg::CHAR_NL);
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            source_text.push_back(s[k]);
    endtask

    // A symbol of the given length: a letter, then letters, digits, '_' and ':'.
    task automatic add_symbol(input int len);
        int pick;
        source_text.push_back(letter_at($urandom_range(0, 51)));
        repeat (len - 1) begin
            pick = $urandom_range(0, 63);
            if (pick < 52)
                source_text.push_back(letter_at(pick));
            else if (pick < 62)
                source_text.push_back(8'(48 + pick - 52));
            else if (pick == 62)
                source_text.push_back(sit_pkg::CHAR_UNDER);
            else
                source_text.push_back(sit_pkg::CHAR_COLON);
        end
    endtask

    task automatic add_integer(input int digits);
        repeat (digits)
            source_text.push_back(8'(48 + $urandom_range(0, 9)));
    endtask

    // A line comment with arbitrary content, bytes with the top bit set included.
    task automatic add_comment(input int len);
        add_text(";;");
        repeat (len)
            source_text.push_back(random_comment_byte());
        source_text.push_back(sit_pkg::CHAR_NL);
    endtask

    task automatic add_blanks();
        int pick;
        repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 7);
            source_text.push_back((pick < 5) ? 8'(9 + pick) : 8'd32);
        end
    endtask

    // What separates a token from the next: blanks, a comment, or for an integer
    // sometimes a symbol that follows with no gap at all.
    task automatic add_gap(input logic after_integer);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            add_comment($urandom_range(0, 12));
        end else if (pick == 1 && after_integer) begin
            add_symbol($urandom_range(1, 8));
            add_blanks();
        end else begin
            add_blanks();
        end
    endtask

    // Build the whole source text: directed part, random tokens, one ending.
    task automatic build_source();
        int         pick;
        int         stop_at;
        logic [7:0] b;

        // Shortest and longest tokens, every blank, comments holding odd bytes,
        // an integer running into a symbol and tokens running into comments.
        add_text("Z z_:9\0110\n999999999999999999\015;;");
        source_text.push_back(8'h80);
        source_text.push_back(8'hFF);
        add_text(";a\n\013\01412ab;;\nq;;\n7;;x\n");
        add_symbol(sit_pkg::MAX_SYMBOL_LENGTH);
        source_text.push_back(8'd32);

        // Mostly well-formed token streams with random content.
        stop_at = source_text.size() + RANDOM_BYTES;
        while (source_text.size() < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                add_symbol(($urandom_range(0, 19) == 0) ?
                           $urandom_range(13, sit_pkg::MAX_SYMBOL_LENGTH) :
                           $urandom_range(1, 12));
                add_gap(1'b0);
            end else if (pick < 85) begin
                add_integer($urandom_range(1, sit_pkg::MAX_INTEGER_DIGITS));
                add_gap(1'b1);
            end else begin
                add_comment($urandom_range(0, 20));
            end
        end

        // The ending halts the block, so the seed picks one per run.
        stop_case = t_stop_case'($urandom_range(0, 6));
        case (stop_case)
            END_IDLE: source_text.push_back(sit_pkg::CHAR_NUL);
            END_AFTER_TOKEN: begin
                if ($urandom_range(0, 1))
                    add_symbol($urandom_range(1, 12));
                else
                    add_integer($urandom_range(1, sit_pkg::MAX_INTEGER_DIGITS));
                source_text.push_back(sit_pkg::CHAR_NUL);
            end
            END_IN_COMMENT: begin
                add_text(";;");
                repeat ($urandom_range(0, 5))
                    source_text.push_back(random_comment_byte());
                source_text.push_back(sit_pkg::CHAR_NUL);
            end
            STOP_LONE_SEMI: begin
                source_text.push_back(sit_pkg::CHAR_SEMI);
                do b = 8'($urandom_range(0, 255)); while (b == sit_pkg::CHAR_SEMI);
                source_text.push_back(b);
            end
            STOP_SYMBOL_LONG: add_symbol(sit_pkg::MAX_SYMBOL_LENGTH + 1);
            STOP_INTEGER_LONG: add_integer(sit_pkg::MAX_INTEGER_DIGITS + 1);
            default: begin
                // Pick from the byte ranges that cannot open a token.
                case ($urandom_range(0, 5))
                    0: b = 8'($urandom_range(1, 8));
                    1: b = 8'($urandom_range(14, 31));
                    2: b = 8'($urandom_range(33, 47));
                    3: b = ($urandom_range(0, 5) == 0) ? sit_pkg::CHAR_COLON :
                                                         8'($urandom_range(60, 64));
                    4: b = 8'($urandom_range(91, 96));
                    default: b = 8'($urandom_range(123, 255));
                endcase
                source_text.push_back(b);
            end
        endcase

        // Bytes after the halt must cause nothing.
        repeat (16)
            source_text.push_back(8'($urandom_range(0, 255)));
    endtask

    // Output side: stalls follow the pacing phase, or a long hold-off.
    always @(posedge clk) begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (flow == FLOW_RECEIVER_STALLS)
            out_ready <= ($urandom_range(0, 99) >= 58);
        else if (flow == FLOW_BOTH)
            out_ready <= ($urandom_range(0, 99) >= 27);
        else
            out_ready <= 1'b1;
    end

    // Long hold-off on the output while bytes keep coming, to fill the queue.
    initial begin
        wait (bytes_sent >= HOLD_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d beats outstanding.",
                     cycle_count, pending);
            $display("symbol_integer_tokenizer test failed");
            $finish;
        end
    end

    // Stimulus: reset, then every source byte as one beat, then drain and verdict.
    initial begin
        int    total;
        t_flow phase;
        int    gap_pct;

        build_source();
        total = source_text.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (source_text[i]) begin
            phase = t_flow'((i * 4) / total);
            flow <= phase;
            gap_pct = (phase == FLOW_SENDER_GAPS) ? 58 : (phase == FLOW_BOTH) ? 27 : 0;
            while ($urandom_range(0, 99) < gap_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid    <= 1'b1;
            source_byte <= source_text[i];
            do @(posedge clk); while (!in_ready);
            bytes_sent++;
        end
        in_valid <= 1'b0;

        // Wait for every owed beat, then a little longer for stray ones.
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d source bytes through four pacing phases and one long output hold-off;",
                 bytes_sent);
        $display("checked %0d result beats, the source ending with the %s case.",
                 beats_checked, stop_case.name());
        if (fail_count == 0)
            $display("symbol_integer_tokenizer test passed");
        else
            $display("symbol_integer_tokenizer test failed");
        $finish;
    end

endmodule
